// File: design/sorted_coordinate_element_store_unit_macros.svh
// Assertion macros for the sorted coordinate element store
`ifndef SORTED_COORDINATE_ELEMENT_STORE_UNIT_MACROS_SVH
`define SORTED_COORDINATE_ELEMENT_STORE_UNIT_MACROS_SVH

`define SCES_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define SCES_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/sces_pkg.sv
package sces_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int INDEX_BITS_DEF = 16;
    localparam int REG_W          = 17;
    localparam int VALUE_W        = 64;
    localparam int COUNT_W        = 11;
    localparam int CFG_IDX_W      = 1;

    localparam logic       FUNC_SET = 1'b0;
    localparam logic       FUNC_GET = 1'b1;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOB   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic       CFG_ROWS = 1'b0;
    localparam logic       CFG_COLS = 1'b1;

    typedef struct packed {
        logic                       func;
        logic [INDEX_BITS_DEF-1:0]  row;
        logic [INDEX_BITS_DEF-1:0]  col;
        logic [VALUE_W-1:0]         value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic                found;
        logic [1:0]          status;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RD, S_WAIT, S_CMP, S_DECIDE,
        S_SHRD, S_SHWAIT, S_SHWR, S_INS, S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic bound;
        logic rd_mid;
        logic cmp;
        logic rd_shift;
        logic wr_shift;
        logic wr_hit;
        logic wr_ins;
        logic rsp_oob;
        logic rsp_full;
        logic rsp_done;
    } cmd_t;

    typedef struct packed {
        logic oob;
        logic search_done;
        logic hit;
        logic full;
        logic is_get;
        logic shift_done;
    } sts_t;

endpackage

// File: design/sorted_coordinate_element_store_unit.sv
// Sparse matrix element store, entries kept sorted by (row, col) in a single-port-write,
// one-read memory. Each request is taken one at a time: a bound check (out-of-range
// requests answer straight after it), a binary search with one memory read per probe,
// then for a new key a shift of every later entry by one place, one read and one write
// per entry. Gets, overwrites and sets to a full store finish after the search. The
// next request is accepted while a response still waits; its own response is held until
// the previous one is taken.
`include "sorted_coordinate_element_store_unit_macros.svh"

module sorted_coordinate_element_store_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sces_pkg::req_t               s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sces_pkg::rsp_t               m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sces_pkg::CFG_IDX_W:0] cfg_index,
    input  logic [sces_pkg::REG_W-1:0]   cfg_data
);

    sces_pkg::cmd_t cmd;
    sces_pkg::sts_t sts;
    logic           rsp_busy;
    logic [sces_pkg::REG_W-1:0] rows_reg, cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= sces_pkg::REG_W'(65536);
            cols_reg <= sces_pkg::REG_W'(65536);
        end else if (cfg_valid && !cfg_index[sces_pkg::CFG_IDX_W]) begin
            unique case (cfg_index[0])
                sces_pkg::CFG_ROWS: rows_reg <= cfg_data;
                sces_pkg::CFG_COLS: cols_reg <= cfg_data;
                default:            rows_reg <= rows_reg;
            endcase
        end
    end

    sces_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .rsp_busy (rsp_busy),
        .sts      (sts),
        .cmd      (cmd)
    );

    sces_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (s_data),
        .rows_in_use (rows_reg),
        .cols_in_use (cols_reg),
        .cmd         (cmd),
        .sts         (sts),
        .rsp_valid   (m_valid),
        .rsp_ready   (m_ready),
        .rsp         (m_data),
        .rsp_busy    (rsp_busy)
    );

    `SCES_ASSERT(a_rsp_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "response changed while stalled")
    `SCES_ASSERT(a_status_code, aclk, aresetn, m_valid |-> m_data.status <= sces_pkg::ST_FULL, "illegal status code")
    `SCES_ASSERT(a_count_cap, aclk, aresetn, m_valid |-> m_data.entry_count <= sces_pkg::COUNT_W'(sces_pkg::CAPACITY_DEF), "count above capacity")
    `SCES_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> !m_valid, "response valid after reset")

endmodule

// File: design/sces_ctrl.sv
module sces_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              rsp_busy,
    input  sces_pkg::sts_t    sts,
    output sces_pkg::cmd_t    cmd
);

    sces_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sces_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sces_pkg::S_IDLE:   if (s_valid) state_next = sces_pkg::S_CHECK;
            sces_pkg::S_CHECK:  state_next = sts.oob ? sces_pkg::S_OUT : sces_pkg::S_RD;
            sces_pkg::S_RD:     state_next = sts.search_done ? sces_pkg::S_DECIDE
                                                             : sces_pkg::S_WAIT;
            sces_pkg::S_WAIT:   state_next = sces_pkg::S_CMP;
            sces_pkg::S_CMP:    state_next = sces_pkg::S_RD;
            sces_pkg::S_DECIDE: begin
                if (sts.hit || sts.is_get || sts.full) state_next = sces_pkg::S_OUT;
                else if (sts.shift_done) state_next = sces_pkg::S_INS;
                else state_next = sces_pkg::S_SHRD;
            end
            sces_pkg::S_SHRD:   state_next = sts.shift_done ? sces_pkg::S_INS
                                                            : sces_pkg::S_SHWAIT;
            sces_pkg::S_SHWAIT: state_next = sces_pkg::S_SHWR;
            sces_pkg::S_SHWR:   state_next = sces_pkg::S_SHRD;
            sces_pkg::S_INS:    state_next = sces_pkg::S_OUT;
            sces_pkg::S_OUT:    if (!rsp_busy) state_next = sces_pkg::S_IDLE;
            default:            state_next = sces_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            sces_pkg::S_IDLE:   begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            sces_pkg::S_CHECK:  cmd.bound = 1'b1;
            sces_pkg::S_RD:     cmd.rd_mid = ~sts.search_done;
            sces_pkg::S_CMP:    cmd.cmp = 1'b1;
            sces_pkg::S_DECIDE: begin
                if (sts.is_get || sts.hit) begin
                    cmd.wr_hit = ~sts.is_get & sts.hit;
                    cmd.rsp_done = 1'b0;
                end else if (sts.full) begin
                    cmd.rsp_full = 1'b1;
                end
            end
            sces_pkg::S_SHRD:   cmd.rd_shift = ~sts.shift_done;
            sces_pkg::S_SHWR:   cmd.wr_shift = 1'b1;
            sces_pkg::S_INS:    cmd.wr_ins = 1'b1;
            sces_pkg::S_OUT:    cmd.rsp_done = ~rsp_busy;
            default:            cmd = '0;
        endcase
        if (state_reg == sces_pkg::S_CHECK) cmd.rsp_oob = sts.oob;
    end

endmodule

// File: design/sces_dp.sv
module sces_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sces_pkg::req_t                    req,
    input  logic [sces_pkg::REG_W-1:0]        rows_in_use,
    input  logic [sces_pkg::REG_W-1:0]        cols_in_use,
    input  sces_pkg::cmd_t                    cmd,
    output sces_pkg::sts_t                    sts,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output sces_pkg::rsp_t                    rsp,
    output logic                              rsp_busy
);

    localparam int CAPACITY   = sces_pkg::CAPACITY_DEF;
    localparam int INDEX_BITS = sces_pkg::INDEX_BITS_DEF;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 2 * INDEX_BITS + sces_pkg::VALUE_W;

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic          re;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic          we;

    sces_pkg::req_t req_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  lo_reg, hi_reg, k_reg;
    logic           oob_reg;
    logic [CW-1:0]  mid;
    logic [INDEX_BITS-1:0] r_key, c_key, e_row, e_col;
    logic           below;
    logic           hit_reg;
    logic [sces_pkg::VALUE_W-1:0] hval_reg;
    logic           rsp_valid_reg;
    sces_pkg::rsp_t rsp_reg;
    logic [1:0]     st_reg;
    logic [CW:0]    lo_hi_sum;

    assign r_key = req_reg.row;
    assign c_key = req_reg.col;
    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid = lo_hi_sum[CW:1];
    assign e_row = rdata_reg[EW-1 -: INDEX_BITS];
    assign e_col = rdata_reg[sces_pkg::VALUE_W +: INDEX_BITS];
    assign below = (e_row < r_key) || (e_row == r_key && e_col < c_key);

    always_comb begin
        re    = cmd.rd_mid | cmd.rd_shift;
        raddr = cmd.rd_mid ? mid[AW-1:0] : AW'(k_reg - CW'(1));
        we    = cmd.wr_shift | cmd.wr_hit | cmd.wr_ins;
        waddr = cmd.wr_shift ? k_reg[AW-1:0] : lo_reg[AW-1:0];
        wdata = cmd.wr_shift ? rdata_reg : {r_key, c_key, req_reg.value};
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= req;
        if (cmd.bound) begin
            oob_reg <= ({1'b0, req_reg.row} >= rows_in_use) ||
                       ({1'b0, req_reg.col} >= cols_in_use);
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            hit_reg <= 1'b0;
            k_reg   <= count_reg;
        end
        if (cmd.cmp) begin
            if (below) begin
                lo_reg <= mid + CW'(1);
            end else begin
                hi_reg <= mid;
                if (e_row == r_key && e_col == c_key) begin
                    hit_reg  <= 1'b1;
                    hval_reg <= rdata_reg[sces_pkg::VALUE_W-1:0];
                end else begin
                    hit_reg <= 1'b0;
                end
            end
            k_reg <= count_reg;
        end
        if (cmd.wr_shift) k_reg <= k_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_ins) count_reg <= count_reg + CW'(1);
            if (cmd.rsp_done) begin
                rsp_valid_reg <= 1'b1;
            end else if (rsp_valid_reg && rsp_ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // hit_reg tracks the lower bound: set only when the last "not below" probe matched
    always_ff @(posedge aclk) begin
        if (cmd.bound) st_reg <= cmd.rsp_oob ? sces_pkg::ST_OOB : sces_pkg::ST_OK;
        if (cmd.rsp_full) st_reg <= sces_pkg::ST_FULL;
        if (cmd.rsp_done) begin
            rsp_reg.status      <= st_reg;
            rsp_reg.entry_count <= sces_pkg::COUNT_W'(count_reg);
            rsp_reg.found       <= ~oob_reg & hit_reg & (st_reg == sces_pkg::ST_OK);
            rsp_reg.read_value  <= (~oob_reg & hit_reg & (req_reg.func == sces_pkg::FUNC_GET))
                                   ? hval_reg : '0;
        end
    end

    assign sts.oob         = ({1'b0, req_reg.row} >= rows_in_use) ||
                             ({1'b0, req_reg.col} >= cols_in_use);
    assign sts.search_done = (lo_reg >= hi_reg);
    assign sts.hit         = hit_reg && (lo_reg < count_reg);
    assign sts.full        = (count_reg >= CW'(CAPACITY));
    assign sts.is_get      = (req_reg.func == sces_pkg::FUNC_GET);
    assign sts.shift_done  = (k_reg <= lo_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_busy  = rsp_valid_reg & ~rsp_ready;

endmodule

// File: sim/sorted_coordinate_element_store_unit_test.sv
`timescale 1ns / 100ps

module sorted_coordinate_element_store_unit_test;

    localparam int STORE_DEPTH = sces_pkg::CAPACITY_DEF;
    localparam logic [sces_pkg::CFG_IDX_W:0] CFG_SPARE = 2'd2;
    localparam int STALL_LIMIT = 20000;

    class element_store_board;
        logic [15:0]                  row_at [STORE_DEPTH];
        logic [15:0]                  col_at [STORE_DEPTH];
        logic [sces_pkg::VALUE_W-1:0] val_at [STORE_DEPTH];
        int                           count;
        logic [sces_pkg::REG_W-1:0]   rows_lim;
        logic [sces_pkg::REG_W-1:0]   cols_lim;
        sces_pkg::rsp_t               awaited[$];
        int                           errors;

        function new();
            count    = 0;
            rows_lim = 17'h10000;
            cols_lim = 17'h10000;
            errors   = 0;
        endfunction

        function void write_reg(logic [sces_pkg::CFG_IDX_W:0] idx,
                                logic [sces_pkg::REG_W-1:0] data);
            if (idx == sces_pkg::CFG_ROWS) begin
                rows_lim = data;
            end else if (idx == sces_pkg::CFG_COLS) begin
                cols_lim = data;
            end
        endfunction

        function int lower_bound(logic [15:0] r, logic [15:0] c);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = count;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (row_at[mid] < r || (row_at[mid] == r && col_at[mid] < c)) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        function void note_request(sces_pkg::req_t q);
            sces_pkg::rsp_t e;
            int   pos;
            bit   hit;
            e = '0;
            e.status = sces_pkg::ST_OK;
            if ({1'b0, q.row} >= rows_lim || {1'b0, q.col} >= cols_lim) begin
                e.status = sces_pkg::ST_OOB;
            end else begin
                pos = lower_bound(q.row, q.col);
                hit = pos < count && row_at[pos] == q.row && col_at[pos] == q.col;
                if (q.func == sces_pkg::FUNC_GET) begin
                    if (hit) begin
                        e.read_value = val_at[pos];
                        e.found      = 1'b1;
                    end
                end else if (hit) begin
                    val_at[pos] = q.value;
                    e.found     = 1'b1;
                end else if (count >= STORE_DEPTH) begin
                    e.status = sces_pkg::ST_FULL;
                end else begin
                    for (int k = count; k > pos; k--) begin
                        row_at[k] = row_at[k-1];
                        col_at[k] = col_at[k-1];
                        val_at[k] = val_at[k-1];
                    end
                    row_at[pos] = q.row;
                    col_at[pos] = q.col;
                    val_at[pos] = q.value;
                    count++;
                end
            end
            e.entry_count = count[sces_pkg::COUNT_W-1:0];
            awaited.push_back(e);
        endfunction

        function void check_response(sces_pkg::rsp_t a);
            sces_pkg::rsp_t e;
            if (awaited.size() == 0) begin
                $error("unexpected response %p", a);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (a.read_value !== e.read_value) begin
                $error("read_value expected %h actual %h", e.read_value, a.read_value);
                errors++;
            end
            if (a.found !== e.found) begin
                $error("found expected %0d actual %0d", e.found, a.found);
                errors++;
            end
            if (a.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, a.status);
                errors++;
            end
            if (a.entry_count !== e.entry_count) begin
                $error("entry_count expected %0d actual %0d", e.entry_count, a.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    sces_pkg::req_t                   s_data;
    logic                             m_valid;
    logic                             m_ready;
    sces_pkg::rsp_t                   m_data;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [sces_pkg::CFG_IDX_W:0]     cfg_index;
    logic [sces_pkg::REG_W-1:0]       cfg_data;

    element_store_board board;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 quiet_cycles;

    sorted_coordinate_element_store_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                board.write_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                board.note_request(s_data);
            end
            if (m_valid && m_ready) begin
                board.check_response(m_data);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("sorted_coordinate_element_store_unit: mismatch");
            $finish;
        end
    end

    task automatic send_request(logic f, logic [15:0] r, logic [15:0] c,
                                logic [sces_pkg::VALUE_W-1:0] v);
        sces_pkg::req_t q;
        q.func  = f;
        q.row   = r;
        q.col   = c;
        q.value = v;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= q;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (board.awaited.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [sces_pkg::CFG_IDX_W:0] idx,
                             logic [sces_pkg::REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [sces_pkg::VALUE_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int items, int row_span, int col_span, int noise_pct);
        logic [15:0] r;
        logic [15:0] c;
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                r = 16'($urandom);
                c = 16'($urandom);
            end else begin
                r = 16'($urandom_range(row_span));
                c = 16'($urandom_range(col_span));
            end
            send_request(1'($urandom_range(1)), r, c, rand_value());
            if (i == items / 2) begin
                hold_until_drained();
            end
        end
        hold_until_drained();
    endtask

    initial begin
        board         = new();
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        quiet_cycles  = 0;
        send_idle_pct = 28;
        recv_idle_pct = 73;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_request(sces_pkg::FUNC_GET, 16'd0, 16'd0, '1);
        send_request(sces_pkg::FUNC_SET, 16'd0, 16'd0, '1);
        send_request(sces_pkg::FUNC_SET, 16'hFFFF, 16'hFFFF, 64'h8000_0000_0000_0001);
        send_request(sces_pkg::FUNC_SET, 16'h00FF, 16'hFF00, '0);
        send_request(sces_pkg::FUNC_GET, 16'hFFFF, 16'hFFFF, '0);
        send_request(sces_pkg::FUNC_GET, 16'd0, 16'd0, '0);
        send_request(sces_pkg::FUNC_SET, 16'd0, 16'd0, 64'h0123_4567_89AB_CDEF);
        send_request(sces_pkg::FUNC_GET, 16'd0, 16'd0, '1);
        send_request(sces_pkg::FUNC_GET, 16'h00FF, 16'hFF00, '0);
        send_request(sces_pkg::FUNC_GET, 16'hAAAA, 16'h5555, '0);
        hold_until_drained();

        write_reg(sces_pkg::CFG_ROWS, 17'd1);
        write_reg(sces_pkg::CFG_COLS, 17'd1);
        send_request(sces_pkg::FUNC_SET, 16'd0, 16'd0, rand_value());
        send_request(sces_pkg::FUNC_SET, 16'd1, 16'd0, rand_value());
        send_request(sces_pkg::FUNC_GET, 16'd0, 16'd1, '0);
        send_request(sces_pkg::FUNC_GET, 16'd0, 16'd0, '0);
        hold_until_drained();
        write_reg(sces_pkg::CFG_ROWS, 17'd0);
        send_request(sces_pkg::FUNC_SET, 16'd0, 16'd0, rand_value());
        send_request(sces_pkg::FUNC_GET, 16'd0, 16'd0, '0);
        hold_until_drained();
        write_reg(CFG_SPARE, 17'd5);
        write_reg(sces_pkg::CFG_ROWS, 17'h10000);
        write_reg(sces_pkg::CFG_COLS, 17'h1FFFF);
        send_request(sces_pkg::FUNC_GET, 16'hFFFF, 16'hFFFF, '0);
        send_request(sces_pkg::FUNC_SET, 16'h1234, 16'hFFFF, rand_value());
        hold_until_drained();

        write_reg(sces_pkg::CFG_ROWS, 17'd24);
        write_reg(sces_pkg::CFG_COLS, 17'd20);
        random_phase(190, 25, 21, 5);

        send_idle_pct = 73;
        recv_idle_pct = 28;
        write_reg(sces_pkg::CFG_ROWS, 17'd40);
        write_reg(sces_pkg::CFG_COLS, 17'd8);
        random_phase(190, 42, 9, 5);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(sces_pkg::CFG_ROWS, 17'h10000);
        write_reg(sces_pkg::CFG_COLS, 17'h10000);
        random_phase(190, 30, 30, 10);

        send_request(sces_pkg::FUNC_SET, 16'hFFFD, 16'd7, rand_value());
        send_request(sces_pkg::FUNC_SET, 16'hFFFE, 16'd0, rand_value());
        send_request(sces_pkg::FUNC_GET, 16'hFFFE, 16'd0, '0);
        send_request(sces_pkg::FUNC_GET, 16'hFFFD, 16'd7, '0);
        hold_until_drained();

        repeat (50) @(negedge aclk);
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("sorted_coordinate_element_store_unit: match");
        end else begin
            $display("sorted_coordinate_element_store_unit: mismatch");
        end
        $finish;
    end
endmodule
